// ===== hdl/otlc_pkg.sv =====
`default_nettype none

package otlc_pkg;

	// field widths
	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int QOFF_W   = 16;
	localparam int LINE_W   = 10;
	localparam int COL_W    = 16;
	localparam int STAT_W   = 2;

	// stream packing, padded to whole bytes
	localparam int IN_DATA_W  = ((BYTE_W + QOFF_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((LINE_W + COL_W + 7) / 8) * 8;

	// defaults for the top-level parameters
	localparam int MAX_LINES_DEF   = 1024;
	localparam int OFFSET_BITS_DEF = 16;

	localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BYTE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BEYOND  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVERFLW = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_FIN = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/offset_to_line_column_core.sv =====
// load items (clear, text byte, finish) are accepted while idle and can follow back to back
// a query on an error status goes straight to the output stage; otherwise it makes one
// newline-table read per binary-search step, the last of which fetches the previous line
// end, and these reads go one at a time through the single table read port
// arst_n clears the counters, flags, sequencer and output valid; the table holds no reset
// and only entries below the entry count are ever used
`default_nettype none

module offset_to_line_column_core
	import otlc_pkg::*;
#(
	parameter int MAX_LINES   = MAX_LINES_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input item stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // text_byte, query_offset
	input  wire logic [CMD_W-1:0]      s_tuser,   // cmd
	// result item stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // line_number, column, zero pad
	output logic [STAT_W-1:0]          m_tuser    // status
);

	localparam int CNT_W = $clog2(MAX_LINES + 1);
	localparam int IDX_W = $clog2(MAX_LINES);
	// compare width covers both the table entries and the query offset
	localparam int CW    = (OFFSET_BITS > QOFF_W) ? OFFSET_BITS : QOFF_W;
	localparam logic [OFFSET_BITS-1:0] POS_MAX   = '1;
	localparam logic [CNT_W-1:0]       LINES_CNT = CNT_W'(MAX_LINES);

	// sequencer codes
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_PREV   = 2'd2;
	localparam logic [1:0] ST_OUT    = 2'd3;

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       count_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   ovf_q;
	logic                   fin_q;
	logic                   m_tvalid_q;

	// search registers
	logic [CNT_W-1:0]       lo_q;
	logic [CNT_W-1:0]       hi_q;
	logic [CNT_W-1:0]       mid_q;
	logic [QOFF_W-1:0]      off_q;
	logic [LINE_W-1:0]      res_line_q;
	logic [COL_W-1:0]       res_col_q;
	logic [STAT_W-1:0]      res_status_q;
	logic [OUT_DATA_W-1:0]  m_tdata_q;
	logic [STAT_W-1:0]      m_tuser_q;

	// newline table, one write port and one registered read port
	logic [OFFSET_BITS-1:0] mem [MAX_LINES];
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_wa;
	logic                   mem_re;
	logic [IDX_W-1:0]       mem_ra;
	logic [OFFSET_BITS-1:0] rd_data_q;

	// input decode
	logic                   s_acc;
	logic [CMD_W-1:0]       cmd;
	logic [BYTE_W-1:0]      text_byte;
	logic [QOFF_W-1:0]      query_offset;
	logic                   pos_at_max;
	logic                   is_nl;
	logic [CNT_W:0]         cnt_inc;
	logic                   room_nl;
	logic                   room_fin;

	// search step
	logic [CW-1:0]          data_ext;
	logic [CW-1:0]          off_ext;
	logic                   ge;
	logic [CNT_W-1:0]       mid_p1;
	logic [CNT_W-1:0]       new_lo;
	logic [CNT_W-1:0]       new_hi;
	logic [CNT_W:0]         mid_sum;
	logic [CNT_W-1:0]       nxt_mid;
	logic                   step_more;
	logic [CNT_W-1:0]       prev_idx;
	logic [CNT_W-1:0]       first_mid;
	logic [CW:0]            col_full;
	logic [CNT_W+LINE_W-1:0] lo_line_ext;
	logic [CNT_W+LINE_W-1:0] new_lo_line_ext;
	logic                   out_free;

	assign s_tready     = (state_q == ST_IDLE);
	assign s_acc        = s_tvalid && s_tready;
	assign cmd          = s_tuser;
	assign text_byte    = s_tdata[BYTE_W-1:0];
	assign query_offset = s_tdata[BYTE_W+QOFF_W-1:BYTE_W];

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign out_free = !m_tvalid_q || m_tready;

	// text loading: newlines need a spare slot for the finish entry
	assign pos_at_max = (pos_q == POS_MAX);
	assign is_nl      = (text_byte == NEWLINE);
	assign cnt_inc    = {1'b0, count_q} + 1'b1;
	assign room_nl    = (cnt_inc < (CNT_W+1)'(MAX_LINES));
	assign room_fin   = (count_q < LINES_CNT);

	// one lower-bound step per cycle on the entry read last cycle
	assign data_ext  = CW'(rd_data_q);
	assign off_ext   = CW'(off_q);
	assign ge        = (data_ext >= off_ext);
	assign mid_p1    = mid_q + 1'b1;
	assign new_lo    = ge ? lo_q : mid_p1;
	assign new_hi    = ge ? mid_q : hi_q;
	assign mid_sum   = {1'b0, new_lo} + {1'b0, new_hi};
	assign nxt_mid   = mid_sum[CNT_W:1];
	assign step_more = (new_lo < new_hi);
	assign prev_idx  = new_lo - 1'b1;
	assign first_mid = count_q >> 1;

	// column from the previous line end: off - (prev + 1)
	assign col_full        = (CW+1)'(off_ext) - (CW+1)'(data_ext) - 1'b1;
	assign lo_line_ext     = (CNT_W+LINE_W)'(lo_q);
	assign new_lo_line_ext = (CNT_W+LINE_W)'(new_lo);

	// table ports; writes happen only on idle loads and reads only while a query
	// runs, so the two never touch the same entry in one cycle
	always_comb begin
		mem_we = 1'b0;
		mem_wa = count_q[IDX_W-1:0];
		mem_re = 1'b0;
		mem_ra = first_mid[IDX_W-1:0];
		if (s_acc && !fin_q) begin
			if (cmd == CMD_BYTE) begin
				mem_we = !pos_at_max && is_nl && room_nl;
			end else if (cmd == CMD_FINISH) begin
				mem_we = room_fin;
			end
		end
		if (s_acc && cmd == CMD_QUERY && fin_q && !ovf_q && count_q != '0) begin
			mem_re = 1'b1;
		end
		if (state_q == ST_SEARCH) begin
			mem_re = 1'b1;
			mem_ra = step_more ? nxt_mid[IDX_W-1:0] : prev_idx[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= pos_q;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			pos_q      <= '0;
			ovf_q      <= 1'b0;
			fin_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a new result may replace the one taken at this edge
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						unique case (cmd)
							CMD_CLEAR: begin
								count_q <= '0;
								pos_q   <= '0;
								ovf_q   <= 1'b0;
								fin_q   <= 1'b0;
							end
							CMD_BYTE: begin
								if (!fin_q) begin
									if (pos_at_max) begin
										ovf_q <= 1'b1;
									end else begin
										pos_q <= pos_q + 1'b1;
										if (is_nl) begin
											if (room_nl) begin
												count_q <= cnt_inc[CNT_W-1:0];
											end else begin
												ovf_q <= 1'b1;
											end
										end
									end
								end
							end
							CMD_FINISH: begin
								if (!fin_q) begin
									fin_q <= 1'b1;
									if (room_fin) begin
										count_q <= cnt_inc[CNT_W-1:0];
									end else begin
										ovf_q <= 1'b1;
									end
								end
							end
							CMD_QUERY: begin
								if (mem_re) begin
									state_q <= ST_SEARCH;
								end else begin
									state_q <= ST_OUT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SEARCH: begin
					if (!step_more) begin
						if (new_lo == count_q || new_lo == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_PREV;
						end
					end
				end
				ST_PREV: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// search and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc && cmd == CMD_QUERY) begin
					off_q      <= query_offset;
					lo_q       <= '0;
					hi_q       <= count_q;
					mid_q      <= first_mid;
					res_line_q <= '0;
					res_col_q  <= '0;
					if (!fin_q) begin
						res_status_q <= STAT_NOT_FIN;
					end else if (ovf_q) begin
						res_status_q <= STAT_OVERFLW;
					end else begin
						// empty table never happens after finish, but reads as beyond end
						res_status_q <= STAT_BEYOND;
					end
				end
			end
			ST_SEARCH: begin
				lo_q  <= new_lo;
				hi_q  <= new_hi;
				mid_q <= nxt_mid;
				if (!step_more) begin
					if (new_lo == count_q) begin
						res_status_q <= STAT_BEYOND;
					end else begin
						// line 0 starts at offset zero
						res_status_q <= STAT_OK;
						res_line_q   <= new_lo_line_ext[LINE_W-1:0];
						res_col_q    <= off_q[COL_W-1:0];
					end
				end
			end
			ST_PREV: begin
				res_line_q <= lo_line_ext[LINE_W-1:0];
				res_col_q  <= col_full[COL_W-1:0];
			end
			ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= OUT_DATA_W'({res_col_q, res_line_q});
					m_tuser_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	// the search window never collapses while a step is pending
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (lo_q < hi_q && hi_q <= count_q))
		else $error("search window empty or past entry count");

	// the table is only written by idle loads, never during a query
	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE && !fin_q))
		else $error("table write outside an idle load");

	// a query before finish goes straight to the output with its status
	a_not_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && cmd == CMD_QUERY && !fin_q) |=>
			(state_q == ST_OUT && res_status_q == STAT_NOT_FIN))
		else $error("unfinished query did not report not-finished");

	// error results carry zero line and column
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && res_status_q != STAT_OK) |->
			(res_line_q == '0 && res_col_q == '0))
		else $error("error result with nonzero line or column");

	// entry count stays within the table
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= LINES_CNT) && (fin_q || count_q < LINES_CNT))
		else $error("entry count beyond table");

endmodule

`default_nettype wire
